// ===== src/stq_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted timeout queue package
// Shared constants, codes and control types of the timer queue.
// ----------------------------------------------------------------------------
package stq_pkg;

  localparam int unsigned QDEPTH     = 16;
  localparam int unsigned CNT_W      = $clog2(QDEPTH + 1);
  localparam int unsigned IDX_W      = $clog2(QDEPTH);
  localparam int unsigned DL_W       = 32;
  localparam int unsigned KEY_W      = 8;
  localparam int unsigned WAIT_W     = 31;
  localparam int unsigned WAIT_CAP_S = 2147483;
  localparam int unsigned SECS_W     = $clog2(WAIT_CAP_S + 1);
  localparam int unsigned MS_PER_S   = 1000;
  localparam int unsigned MS_W       = $clog2(MS_PER_S + 1);

  typedef enum logic [1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_CANCEL = 2'd1,
    FUNC_TICK   = 2'd2,
    FUNC_RSVD   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    KIND_ADD     = 2'd0,
    KIND_CANCEL  = 2'd1,
    KIND_EXPIRED = 2'd2,
    KIND_SUMMARY = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NOTFOUND = 2'd1,
    STAT_FULL     = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    OP_NOP    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_INSERT = 2'd2
  } st_op_e;

  typedef struct packed {
    st_op_e            op;
    logic [IDX_W-1:0]  pos;
    logic [DL_W-1:0]   deadline;
    logic [KEY_W-1:0]  key;
  } stq_ctl_t;

  typedef struct packed {
    logic              le;
    logic              key_eq;
    logic [SECS_W-1:0] secs;
  } stq_alu_t;

endpackage

// ===== src/stq_alu.sv =====
// ----------------------------------------------------------------------------
// Timer queue compare unit
// Shared compare/subtract: key match, deadline at or before now, capped wait.
// ----------------------------------------------------------------------------
module stq_alu import stq_pkg::*; (
  input  logic [DL_W-1:0]  deadline_i,
  input  logic [DL_W-1:0]  now_i,
  input  logic [KEY_W-1:0] key_i,
  input  logic [KEY_W-1:0] id_i,
  output stq_alu_t         res_o
);

  logic [DL_W:0] diff;

  assign diff          = {1'b0, deadline_i} - {1'b0, now_i};
  assign res_o.le      = diff[DL_W] | (diff[DL_W-1:0] == '0);
  assign res_o.key_eq  = (key_i == id_i);
  assign res_o.secs    = (diff[DL_W-1:0] > DL_W'(WAIT_CAP_S)) ? SECS_W'(WAIT_CAP_S)
                                                             : diff[SECS_W-1:0];

endmodule

// ===== src/stq_store.sv =====
// ----------------------------------------------------------------------------
// Timer queue storage
// Sorted entry registers with one read index, shift-remove and shift-insert.
// ----------------------------------------------------------------------------
module stq_store import stq_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  stq_ctl_t         ctl_i,
  input  logic [IDX_W-1:0] rd_idx_i,
  output logic [DL_W-1:0]  rd_deadline_o,
  output logic [KEY_W-1:0] rd_key_o,
  output logic [CNT_W-1:0] count_o
);

  logic [DL_W-1:0]  dl_q  [QDEPTH];
  logic [KEY_W-1:0] key_q [QDEPTH];
  logic [CNT_W-1:0] count_q;

  assign rd_deadline_o = dl_q[rd_idx_i];
  assign rd_key_o      = key_q[rd_idx_i];
  assign count_o       = count_q;

  always_ff @(posedge clk_i) begin
    unique case (ctl_i.op)
      OP_REMOVE: begin
        for (int i = 0; i < QDEPTH - 1; i++) begin
          if (IDX_W'(i) >= ctl_i.pos) begin
            dl_q[i]  <= dl_q[i+1];
            key_q[i] <= key_q[i+1];
          end
        end
      end
      OP_INSERT: begin
        for (int i = 1; i < QDEPTH; i++) begin
          if (IDX_W'(i) > ctl_i.pos) begin
            dl_q[i]  <= dl_q[i-1];
            key_q[i] <= key_q[i-1];
          end
        end
        dl_q[ctl_i.pos]  <= ctl_i.deadline;
        key_q[ctl_i.pos] <= ctl_i.key;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      unique case (ctl_i.op)
        OP_REMOVE: count_q <= count_q - CNT_W'(1);
        OP_INSERT: count_q <= count_q + CNT_W'(1);
        default:   ;
      endcase
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QDEPTH))
    else $error("entry count above queue depth");

  a_remove_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.op == OP_REMOVE |-> count_q != '0)
    else $error("remove from empty queue");

  a_insert_notfull: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.op == OP_INSERT |-> count_q < CNT_W'(QDEPTH) && CNT_W'(ctl_i.pos) <= count_q)
    else $error("insert into full queue or past the tail");

endmodule

// ===== src/sorted_timeout_queue_core.sv =====
// ----------------------------------------------------------------------------
// Sorted timeout queue core
// Deadline-sorted timer queue: add/replace, cancel and tick with expiry list.
// Steps: add/cancel walk the queue for the key, then for add walk it for the
//   slot, then issue the response.
// Tick pops each expired entry from the head, then sends a summary.
// One item at a time; the walk through the shared compare unit sets the rate.
// Reset clears the state, the output valid and the entry count; entry contents need no clearing.
// ----------------------------------------------------------------------------
module sorted_timeout_queue_core import stq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        func_i,
  input  logic [KEY_W-1:0]  timer_id_i,
  input  logic [DL_W-1:0]   time_value_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        kind_o,
  output logic [KEY_W-1:0]  expired_id_o,
  output logic [1:0]        status_o,
  output logic              pending_o,
  output logic [WAIT_W-1:0] wait_ms_o,
  output logic              last_o
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_FIND   = 6'b000010,
    S_SEARCH = 6'b000100,
    S_RESP   = 6'b001000,
    S_POP    = 6'b010000,
    S_SUM    = 6'b100000
  } state_e;

  state_e            state_q, state_d;
  func_e             func_q;
  logic [KEY_W-1:0]  id_q;
  logic [DL_W-1:0]   tv_q;
  logic [CNT_W-1:0]  idx_q, idx_d;
  status_e           status_q, status_d;
  logic [SECS_W-1:0] secs_q, secs_d;
  logic              pend_q, pend_d;

  logic              out_valid_q;
  kind_e             kind_q, kind_d;
  logic [KEY_W-1:0]  oid_q, oid_d;
  status_e           ostat_q, ostat_d;
  logic              opend_q, opend_d;
  logic [WAIT_W-1:0] owait_q, owait_d;
  logic              olast_q, olast_d;
  logic              out_load;

  stq_ctl_t          ctl;
  stq_alu_t          alu;
  logic [DL_W-1:0]   rd_deadline;
  logic [KEY_W-1:0]  rd_key;
  logic [CNT_W-1:0]  count;
  logic [IDX_W-1:0]  rd_idx;
  logic              accept;
  logic              out_free;
  logic              idx_lt_cnt;
  logic [SECS_W+MS_W-1:0] wait_full;

  assign rd_idx     = idx_q[IDX_W-1:0];
  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i & ~in_stall_o;
  assign out_free   = ~out_valid_q | ~out_stall_i;
  assign idx_lt_cnt = (idx_q < count);
  assign wait_full  = secs_q * MS_W'(MS_PER_S);

  stq_store u_store (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .rd_idx_i      (rd_idx),
    .rd_deadline_o (rd_deadline),
    .rd_key_o      (rd_key),
    .count_o       (count)
  );

  stq_alu u_alu (
    .deadline_i (rd_deadline),
    .now_i      (tv_q),
    .key_i      (rd_key),
    .id_i       (id_q),
    .res_o      (alu)
  );

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    status_d = status_q;
    secs_d   = secs_q;
    pend_d   = pend_q;
    ctl      = '{op: OP_NOP, pos: rd_idx, deadline: tv_q, key: id_q};
    out_load = 1'b0;
    kind_d   = KIND_ADD;
    oid_d    = id_q;
    ostat_d  = STAT_OK;
    opend_d  = 1'b0;
    owait_d  = '0;
    olast_d  = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        idx_d    = '0;
        status_d = STAT_OK;
        if (accept) begin
          unique case (func_e'(func_i))
            FUNC_ADD, FUNC_CANCEL: state_d = S_FIND;
            FUNC_TICK:             state_d = S_POP;
            default:               state_d = S_IDLE;
          endcase
        end
      end
      S_FIND: begin
        if (idx_lt_cnt) begin
          if (alu.key_eq) begin
            ctl.op = OP_REMOVE;
            idx_d  = '0;
            state_d = (func_q == FUNC_CANCEL) ? S_RESP : S_SEARCH;
          end else begin
            idx_d = idx_q + CNT_W'(1);
          end
        end else if (func_q == FUNC_CANCEL) begin
          status_d = STAT_NOTFOUND;
          state_d  = S_RESP;
        end else if (count >= CNT_W'(QDEPTH)) begin
          status_d = STAT_FULL;
          state_d  = S_RESP;
        end else begin
          idx_d   = '0;
          state_d = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (idx_lt_cnt && alu.le) begin
          idx_d = idx_q + CNT_W'(1);
        end else begin
          ctl.op  = OP_INSERT;
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_load = 1'b1;
          kind_d   = (func_q == FUNC_CANCEL) ? KIND_CANCEL : KIND_ADD;
          ostat_d  = status_q;
          state_d  = S_IDLE;
        end
      end
      S_POP: begin
        if (count != '0 && alu.le) begin
          if (out_free) begin
            out_load = 1'b1;
            kind_d   = KIND_EXPIRED;
            oid_d    = rd_key;
            olast_d  = 1'b0;
            ctl.op   = OP_REMOVE;
          end
        end else begin
          pend_d  = (count != '0);
          secs_d  = (count != '0) ? alu.secs : '0;
          state_d = S_SUM;
        end
      end
      S_SUM: begin
        if (out_free) begin
          out_load = 1'b1;
          kind_d   = KIND_SUMMARY;
          oid_d    = '0;
          opend_d  = pend_q;
          owait_d  = wait_full[WAIT_W-1:0];
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= func_e'(func_i);
      id_q   <= timer_id_i;
      tv_q   <= time_value_i;
    end
    idx_q    <= idx_d;
    status_q <= status_d;
    secs_q   <= secs_d;
    pend_q   <= pend_d;
    if (out_load) begin
      kind_q  <= kind_d;
      oid_q   <= oid_d;
      ostat_q <= ostat_d;
      opend_q <= opend_d;
      owait_q <= owait_d;
      olast_q <= olast_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = kind_q;
  assign expired_id_o = oid_q;
  assign status_o     = ostat_q;
  assign pending_o    = opend_q;
  assign wait_ms_o    = owait_q;
  assign last_o       = olast_q;

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_free)
    else $error("result register overwritten while stalled");

  a_pop_only_expired: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POP && ctl.op == OP_REMOVE) |-> (alu.le && rd_idx == '0))
    else $error("tick removed an entry that has not expired");

  a_summary_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SUM) |-> (pend_q == (count != '0)))
    else $error("summary pending flag disagrees with queue count");

endmodule

// ===== bench/tb_sorted_timeout_queue_core.sv =====
// ----------------------------------------------------------------------------
// Sorted timeout queue core testbench
// A directed table covers empty and full queues, replace, equal deadlines,
// capped waits and a full flush. A random mix of add, cancel, tick and reserved
// items follows, with fill bursts and a long output hold. Results are checked
// against a behavioral copy of the deadline-sorted queue.
// ----------------------------------------------------------------------------
module tb_sorted_timeout_queue_core;
  import stq_pkg::*;

  localparam int          DIR_ROWS    = 18;
  localparam int          PHASE_ITEMS = 105;
  localparam int          HOLD_CYCLES = 300;
  localparam int          TAIL_CYCLES = 60;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct {
    kind_e              kind;
    logic [KEY_W-1:0]   id;
    status_e            status;
    logic               pending;
    logic [WAIT_W-1:0]  wait_ms;
    logic               last;
  } timer_res_t;

  typedef struct {
    func_e              fn;
    logic [KEY_W-1:0]   id;
    logic [DL_W-1:0]    tv;
    int                 rep;
    bit                 fixed;
    timer_res_t         res;
  } stim_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [1:0]        func_i;
  logic [KEY_W-1:0]  timer_id_i;
  logic [DL_W-1:0]   time_value_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [1:0]        kind_o;
  logic [KEY_W-1:0]  expired_id_o;
  logic [1:0]        status_o;
  logic              pending_o;
  logic [WAIT_W-1:0] wait_ms_o;
  logic              last_o;

  // behavioral queue
  logic [DL_W-1:0]   tq_deadline [QDEPTH];
  logic [KEY_W-1:0]  tq_key      [QDEPTH];
  int                tq_count;

  timer_res_t        awaited_res [$];
  timer_res_t        exp_r;
  stim_row_t         dir_tab [DIR_ROWS];
  timer_res_t        no_res;
  logic [DL_W-1:0]   clock_now;
  int unsigned       in_idle_pct  = 9;
  int unsigned       out_idle_pct = 72;
  bit                hold_go      = 1'b0;
  int unsigned       err_cnt      = 0;
  int unsigned       cycle_cnt;

  sorted_timeout_queue_core i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .timer_id_i   (timer_id_i),
    .time_value_i (time_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .kind_o       (kind_o),
    .expired_id_o (expired_id_o),
    .status_o     (status_o),
    .pending_o    (pending_o),
    .wait_ms_o    (wait_ms_o),
    .last_o       (last_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic void post_res(kind_e k, logic [KEY_W-1:0] id, status_e st,
                                   logic pend, logic [WAIT_W-1:0] w, logic lst);
    timer_res_t r;
    r = '{k, id, st, pend, w, lst};
    awaited_res.push_back(r);
  endfunction

  function automatic void tq_remove(int p);
    int i;
    for (i = p; i + 1 < tq_count; i++) begin
      tq_deadline[i] = tq_deadline[i + 1];
      tq_key[i]      = tq_key[i + 1];
    end
    tq_count--;
  endfunction

  function automatic void timer_queue_apply(func_e fn, logic [KEY_W-1:0] id,
                                            logic [DL_W-1:0] tv);
    int                pos;
    int                i;
    longint unsigned   secs;
    logic [WAIT_W-1:0] w;
    pos = tq_count;
    for (i = tq_count - 1; i >= 0; i--) begin
      if (tq_key[i] == id) pos = i;
    end
    case (fn)
      FUNC_ADD: begin
        if (pos < tq_count) begin
          tq_remove(pos);
        end else if (tq_count >= QDEPTH) begin
          post_res(KIND_ADD, id, STAT_FULL, 1'b0, '0, 1'b1);
          return;
        end
        pos = 0;
        while (pos < tq_count && tq_deadline[pos] <= tv) pos++;
        for (i = tq_count; i > pos; i--) begin
          tq_deadline[i] = tq_deadline[i - 1];
          tq_key[i]      = tq_key[i - 1];
        end
        tq_deadline[pos] = tv;
        tq_key[pos]      = id;
        tq_count++;
        post_res(KIND_ADD, id, STAT_OK, 1'b0, '0, 1'b1);
      end
      FUNC_CANCEL: begin
        if (pos < tq_count) begin
          tq_remove(pos);
          post_res(KIND_CANCEL, id, STAT_OK, 1'b0, '0, 1'b1);
        end else begin
          post_res(KIND_CANCEL, id, STAT_NOTFOUND, 1'b0, '0, 1'b1);
        end
      end
      FUNC_TICK: begin
        while (tq_count > 0 && tq_deadline[0] <= tv) begin
          post_res(KIND_EXPIRED, tq_key[0], STAT_OK, 1'b0, '0, 1'b0);
          tq_remove(0);
        end
        if (tq_count > 0) begin
          secs = longint'(tq_deadline[0]) - longint'(tv);
          if (secs > WAIT_CAP_S) secs = WAIT_CAP_S;
          w = WAIT_W'(secs * MS_PER_S);
          post_res(KIND_SUMMARY, '0, STAT_OK, 1'b1, w, 1'b1);
        end else begin
          post_res(KIND_SUMMARY, '0, STAT_OK, 1'b0, '0, 1'b1);
        end
      end
      default: ;
    endcase
  endfunction

  // called at a falling edge, returns at a falling edge with valid still high
  task automatic send_item(func_e fn, logic [KEY_W-1:0] id, logic [DL_W-1:0] tv);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    func_i       <= fn;
    timer_id_i   <= id;
    time_value_i <= tv;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    timer_queue_apply(fn, id, tv);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (awaited_res.size() != 0) @(negedge clk_i);
  endtask

  task automatic send_random(output bit counted);
    int unsigned      sel;
    func_e            fn;
    logic [KEY_W-1:0] id;
    logic [DL_W-1:0]  tv;
    sel     = $urandom_range(0, 99);
    id      = ($urandom_range(0, 3) == 0) ? KEY_W'($urandom) : KEY_W'($urandom_range(0, 23));
    tv      = clock_now + $urandom_range(0, 40);
    counted = 1'b1;
    if (sel < 46) begin
      fn = FUNC_ADD;
      case ($urandom_range(0, 9))
        0: tv = $urandom;
        1: tv = clock_now;
        2: tv = '1;
        default: ;
      endcase
    end else if (sel < 68) begin
      fn = FUNC_CANCEL;
      if ($urandom_range(0, 4) == 0) tv = $urandom;
    end else if (sel < 95) begin
      fn = FUNC_TICK;
      id = KEY_W'($urandom);
      case ($urandom_range(0, 9))
        0: tv = $urandom;
        1: tv = '1;
        default: begin
          clock_now = clock_now + $urandom_range(0, 12);
          tv = clock_now;
        end
      endcase
    end else begin
      fn      = FUNC_RSVD;
      id      = KEY_W'($urandom);
      tv      = $urandom;
      counted = 1'b0;
    end
    send_item(fn, id, tv);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_res.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result kind=%0d id=%0d st=%0d pend=%0d wait=%0d last=%0d",
                 $time, kind_o, expired_id_o, status_o, pending_o, wait_ms_o, last_o);
      end else begin
        exp_r = awaited_res.pop_front();
        if (kind_o !== exp_r.kind || expired_id_o !== exp_r.id ||
            status_o !== exp_r.status || pending_o !== exp_r.pending ||
            wait_ms_o !== exp_r.wait_ms || last_o !== exp_r.last) begin
          err_cnt++;
          $display("%0t: mismatch exp kind=%0d id=%0d st=%0d pend=%0d wait=%0d last=%0d",
                   $time, exp_r.kind, exp_r.id, exp_r.status, exp_r.pending,
                   exp_r.wait_ms, exp_r.last);
          $display("%0t:          got kind=%0d id=%0d st=%0d pend=%0d wait=%0d last=%0d",
                   $time, kind_o, expired_id_o, status_o, pending_o, wait_ms_o, last_o);
        end
      end
    end
  end

  // output side: random stall, or a long hold on request
  initial begin
    int n;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_go) begin
        hold_go = 1'b0;
        for (n = 0; n < HOLD_CYCLES; n++) begin
          out_stall_i <= 1'b1;
          @(negedge clk_i);
        end
      end
      out_stall_i <= ($urandom_range(0, 99) < out_idle_pct);
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("tb_sorted_timeout_queue_core: done, errors");
    $finish;
  end

  initial begin
    int  row;
    int  k;
    int  phase;
    int  done_items;
    bit  counted;
    bit  hold_done;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    func_i       = FUNC_ADD;
    timer_id_i   = '0;
    time_value_i = '0;
    tq_count     = 0;
    hold_done    = 1'b0;
    clock_now    = $urandom_range(0, 1000);
    no_res       = '{KIND_ADD, 8'h00, STAT_OK, 1'b0, 31'd0, 1'b0};
    dir_tab = '{
      '{FUNC_TICK,   8'h00, 32'd0, 1, 1'b1,
        '{KIND_SUMMARY, 8'h00, STAT_OK, 1'b0, 31'd0, 1'b1}},
      '{FUNC_CANCEL, 8'h00, 32'd0, 1, 1'b1,
        '{KIND_CANCEL, 8'h00, STAT_NOTFOUND, 1'b0, 31'd0, 1'b1}},
      '{FUNC_RSVD,   8'hFF, 32'hFFFF_FFFF, 1, 1'b0, no_res},
      '{FUNC_ADD,    8'hFF, 32'hFFFF_FFFF, 1, 1'b0, no_res},
      '{FUNC_ADD,    8'h00, 32'd0,   1, 1'b0, no_res},
      '{FUNC_ADD,    8'h01, 32'd5,   1, 1'b0, no_res},
      '{FUNC_ADD,    8'h02, 32'd5,   1, 1'b0, no_res},
      '{FUNC_ADD,    8'h01, 32'd3,   1, 1'b0, no_res},
      '{FUNC_ADD,    8'h03, 32'd5,   1, 1'b0, no_res},
      '{FUNC_TICK,   8'hAA, 32'd4,   1, 1'b0, no_res},
      '{FUNC_CANCEL, 8'h02, 32'd0,   1, 1'b0, no_res},
      '{FUNC_TICK,   8'h00, 32'd5,   1, 1'b0, no_res},
      '{FUNC_TICK,   8'h00, 32'd0,   1, 1'b1,
        '{KIND_SUMMARY, 8'h00, STAT_OK, 1'b1, 31'd2147483000, 1'b1}},
      '{FUNC_ADD,    8'h10, 32'd100, 15, 1'b0, no_res},
      '{FUNC_ADD,    8'h09, 32'd1,   1, 1'b1,
        '{KIND_ADD, 8'h09, STAT_FULL, 1'b0, 31'd0, 1'b1}},
      '{FUNC_ADD,    8'hFF, 32'd7,   1, 1'b0, no_res},
      '{FUNC_TICK,   8'h00, 32'hFFFF_FFFF, 1, 1'b0, no_res},
      '{FUNC_TICK,   8'hFF, 32'hFFFF_FFFF, 1, 1'b1,
        '{KIND_SUMMARY, 8'h00, STAT_OK, 1'b0, 31'd0, 1'b1}}
    };
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (row = 0; row < DIR_ROWS; row++) begin
      for (k = 0; k < dir_tab[row].rep; k++) begin
        send_item(dir_tab[row].fn, dir_tab[row].id + KEY_W'(k), dir_tab[row].tv + k);
        if (dir_tab[row].fixed) begin
          void'(awaited_res.pop_back());
          awaited_res.push_back(dir_tab[row].res);
        end
      end
    end
    drain_results();

    for (phase = 0; phase < 3; phase++) begin
      in_idle_pct  = (phase == 0) ? 9 : (phase == 1) ? 72 : 0;
      out_idle_pct = (phase == 0) ? 72 : (phase == 1) ? 9 : 0;
      done_items   = 0;
      while (done_items < PHASE_ITEMS) begin
        if (phase == 0 && !hold_done && done_items >= 30) begin
          hold_go   = 1'b1;
          hold_done = 1'b1;
        end
        if ($urandom_range(0, 39) == 0) begin
          // fill burst, runs into the full queue
          repeat (QDEPTH + 3)
            send_item(FUNC_ADD, KEY_W'($urandom), clock_now + $urandom_range(0, 60));
          done_items += QDEPTH + 3;
        end else begin
          send_random(counted);
          if (counted) done_items++;
        end
      end
      drain_results();
    end

    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (err_cnt == 0)
      $display("tb_sorted_timeout_queue_core: done, clean");
    else
      $display("tb_sorted_timeout_queue_core: done, errors");
    $finish;
  end

endmodule
